@@ rtl/core/assert_macros.svh @@
// assertion macros for the rtl of the arc sum search block
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent at an edge implies the consequent at the same edge
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/cats_pkg.sv @@
// package for the arc sum search block: sequencer state encoding
// no dependencies
package cats_pkg;

    typedef enum logic [5:0] {
        S_LOAD   = 6'b000001,
        S_READ_T = 6'b000010,
        S_ADD_T  = 6'b000100,
        S_CHECK  = 6'b001000,
        S_SUB    = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

endpackage

@@ rtl/core/cats_if.sv @@
// valid/ready channel interfaces for ring values in and search results out
// no dependencies
interface cats_piece_if #(parameter int VALUE_BITS = 32);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] piece_value;
    logic                  last_piece;

    modport source (output valid, output piece_value, output last_piece, input ready);
    modport sink   (input valid, input piece_value, input last_piece, output ready);
endinterface

interface cats_result_if;
    logic valid;
    logic ready;
    logic found;

    modport source (output valid, output found, input ready);
    modport sink   (input valid, input found, output ready);
endinterface

@@ rtl/core/cats_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module cats_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/core/cats_div.sv @@
// constant scaler: multiplies a ring value by the fraction divisor
// no dependencies
module cats_div #(
    parameter int VALUE_BITS = 32,
    parameter int DIVISOR    = 10,
    localparam int DIV_BITS  = $clog2(DIVISOR + 1),
    localparam int PROD_BITS = VALUE_BITS + DIV_BITS
) (
    input  logic [VALUE_BITS-1:0] value,
    output logic [PROD_BITS-1:0]  scaled
);

    localparam logic [PROD_BITS-1:0] DIV_K = PROD_BITS'(DIVISOR);

    assign scaled = PROD_BITS'(value) * DIV_K;

endmodule

@@ rtl/core/circular_arc_target_sum_search.sv @@
// top level of the circular arc target sum search: load sequencer, scaler, window search
// depends on cats_pkg, cats_if, cats_ram, cats_div and assert_macros.svh
//
//  channel   dir  fields                      transaction
//  piece     in   piece_value, last_piece     one ring element
//  result    out  found                       one answer per ring
//
// loading takes one value per cycle; values beyond MAX_ITEMS are dropped
// the window sum is kept scaled by FRACTION_DIVISOR and compared with the total
// each tail step is a ram read then an add, and each head step at most a failed tail try
// (read, add), a check and a subtract; piece is not ready while the search runs,
// and a waiting result holds the next ring in the finish step
// reset clears control state only; ring contents are undefined until written
`include "assert_macros.svh"

module circular_arc_target_sum_search
    import cats_pkg::*;
#(
    parameter int MAX_ITEMS        = 1024,
    parameter int VALUE_BITS       = 32,
    parameter int FRACTION_DIVISOR = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    cats_piece_if.sink         piece,
    cats_result_if.source      result
);

    localparam int TOTAL_BITS = VALUE_BITS + $clog2(MAX_ITEMS);
    localparam int DIV_BITS   = $clog2(FRACTION_DIVISOR + 1);
    localparam int PROD_BITS  = VALUE_BITS + DIV_BITS;
    localparam int WIDE_BITS  = (TOTAL_BITS > PROD_BITS) ? TOTAL_BITS : PROD_BITS;
    localparam int SUM_BITS   = WIDE_BITS + 1;
    localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);
    localparam int POS_BITS   = CNT_BITS + 1;
    localparam int ADDR_BITS  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

    localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_ITEMS);
    localparam logic [CNT_BITS-1:0] CNT_ONE = CNT_BITS'(1);
    localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

    state_t                  state_reg, state_next;
    logic [CNT_BITS-1:0]     cnt_reg, cnt_next;
    logic [TOTAL_BITS-1:0]   total_reg, total_next;
    logic [TOTAL_BITS-1:0]   ws_reg, ws_next;
    logic [POS_BITS-1:0]     head_reg, head_next;
    logic [POS_BITS-1:0]     tail_reg, tail_next;
    logic                    hit_reg, hit_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    found_reg, found_next;

    logic                    accept;
    logic                    room;
    logic                    search_start;
    logic [POS_BITS-1:0]     span;
    logic [POS_BITS-1:0]     pos;
    logic [POS_BITS-1:0]     idx;
    logic [POS_BITS-1:0]     head_inc;
    logic [ADDR_BITS-1:0]    wr_addr;
    logic [VALUE_BITS-1:0]   rd_data;
    logic [PROD_BITS-1:0]    rd_scaled;
    logic                    alu_sub;
    logic [SUM_BITS-1:0]     alu_op;
    logic [SUM_BITS-1:0]     alu_res;
    logic                    alu_fits;

    assign accept       = piece.valid && piece.ready;
    assign room         = (cnt_reg < CNT_MAX);
    assign search_start = accept && piece.last_piece;
    assign span         = {cnt_reg, 1'b0};
    assign head_inc     = head_reg + POS_ONE;
    assign wr_addr      = cnt_reg[ADDR_BITS-1:0];

    // ring position folded back into the stored range
    assign pos = (state_reg == S_CHECK) ? head_reg : tail_reg;
    assign idx = (pos >= {1'b0, cnt_reg}) ? pos - {1'b0, cnt_reg} : pos;

    // shared add/subtract unit for the scaled window sum, compared against the total
    // a total that the divisor does not divide never matches
    assign alu_sub  = (state_reg == S_SUB);
    assign alu_op   = SUM_BITS'(rd_scaled);
    assign alu_res  = SUM_BITS'(ws_reg) + (alu_sub ? ~alu_op : alu_op) + SUM_BITS'(alu_sub);
    assign alu_fits = (alu_res <= SUM_BITS'(total_reg));

    cats_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ITEMS)
    ) u_ring (
        .clk     (clk),
        .wr_en   (accept && room),
        .wr_addr (wr_addr),
        .wr_data (piece.piece_value),
        .rd_addr (idx[ADDR_BITS-1:0]),
        .rd_data (rd_data)
    );

    cats_div #(
        .VALUE_BITS (VALUE_BITS),
        .DIVISOR    (FRACTION_DIVISOR)
    ) u_div (
        .value  (rd_data),
        .scaled (rd_scaled)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        total_next     = total_reg;
        ws_next        = ws_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        found_next     = found_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_LOAD:
            begin
                if (accept && room)
                begin
                    total_next = total_reg + TOTAL_BITS'(piece.piece_value);
                    cnt_next   = cnt_reg + CNT_ONE;
                end
                if (search_start)
                begin
                    state_next = S_READ_T;
                end
            end
            S_READ_T:
            begin
                // read of ring at tail is issued here when tail is in range
                state_next = (tail_reg < span) ? S_ADD_T : S_CHECK;
            end
            S_ADD_T:
            begin
                if (alu_fits)
                begin
                    ws_next    = alu_res[TOTAL_BITS-1:0];
                    tail_next  = tail_reg + POS_ONE;
                    state_next = S_READ_T;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (ws_reg == total_reg)
                begin
                    hit_next   = 1'b1;
                    state_next = S_FINISH;
                end
                else if (head_reg == tail_reg)
                begin
                    // empty window: step both pointers
                    head_next = head_inc;
                    tail_next = tail_reg + POS_ONE;
                    if (head_inc < span)
                    begin
                        state_next = S_READ_T;
                    end
                    else
                    begin
                        hit_next   = 1'b0;
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    // read of ring at head issued here, removed next cycle
                    state_next = S_SUB;
                end
            end
            S_SUB:
            begin
                ws_next   = alu_res[TOTAL_BITS-1:0];
                head_next = head_inc;
                if (head_inc < span)
                begin
                    state_next = S_READ_T;
                end
                else
                begin
                    hit_next   = 1'b0;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    found_next     = hit_reg;
                    cnt_next       = '0;
                    total_next     = '0;
                    ws_next        = '0;
                    head_next      = '0;
                    tail_next      = '0;
                    state_next     = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cnt_reg       <= '0;
            total_reg     <= '0;
            ws_reg        <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            total_reg     <= total_next;
            ws_reg        <= ws_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
    end

    assign piece.ready  = (state_reg == S_LOAD);
    assign result.valid = out_valid_reg;
    assign result.found = found_reg;

    `ASSERT_IMPLIES(a_result_from_finish, out_valid_reg && !$past(out_valid_reg),
                    $past(state_reg == S_FINISH), "result raised outside the finish step")
    `ASSERT_ALWAYS(a_tail_in_span, tail_reg <= span, "tail pointer ran past twice the ring length")
    `ASSERT_ALWAYS(a_head_behind_tail, head_reg <= tail_reg, "head pointer overtook tail pointer")
    `ASSERT_IMPLIES(a_window_below_goal, state_reg == S_READ_T || state_reg == S_CHECK,
                    ws_reg <= total_reg, "window sum exceeded the target")

endmodule

@@ bench/arc_search_checker.sv @@
// transaction checker for the circular arc target sum search: watches both channels,
// predicts the found flag of every ring and compares it with the block's answer
// depends on cats_if (cats_piece_if, cats_result_if)
module arc_search_checker #(
    parameter int MAX_ITEMS        = 1024,
    parameter int FRACTION_DIVISOR = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    cats_piece_if       piece,
    cats_result_if      result,
    output int unsigned mismatches,
    output int unsigned awaiting
);

    bit [31:0]   ring_vals [MAX_ITEMS];
    bit [41:0]   held_total;
    bit [10:0]   held_count;
    bit          expected_found [$];
    bit          want_found;
    int unsigned fail_tally;

    function automatic bit [31:0] ring_val(input bit [11:0] pos);
        bit [11:0] idx;
        idx = (pos >= held_count) ? pos - held_count : pos;
        return ring_vals[idx[9:0]];
    endfunction

    // two-pointer window over the ring laid out twice
    function automatic bit ring_has_target_arc();
        bit [41:0] goal;
        bit [41:0] win;
        bit [11:0] span;
        bit [11:0] hd;
        bit [11:0] tl;
        if (held_total % 42'(FRACTION_DIVISOR) != 0)
            return 1'b0;
        goal = held_total / 42'(FRACTION_DIVISOR);
        if (held_count == 0)
            return 1'b1;
        span = 12'(held_count) * 2;
        win  = '0;
        tl   = '0;
        for (hd = 0; hd < span; hd++)
        begin
            while (tl < span && win + 42'(ring_val(tl)) <= goal)
            begin
                win += 42'(ring_val(tl));
                tl++;
            end
            if (win == goal)
                return 1'b1;
            if (hd == tl)
                tl++;
            else
                win -= 42'(ring_val(hd));
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_found.delete();
            held_total = '0;
            held_count = '0;
            fail_tally = 0;
            mismatches <= 0;
            awaiting   <= 0;
        end
        else
        begin
            // results belong to older rings, so check before taking a new piece
            if (result.valid && result.ready)
            begin
                if (expected_found.size() == 0)
                begin
                    fail_tally++;
                    $error("found: unexpected transaction, expected none, actual %0d",
                           result.found);
                end
                else
                begin
                    want_found = expected_found.pop_front();
                    if (want_found !== result.found)
                    begin
                        fail_tally++;
                        $error("found mismatch: expected %0d, actual %0d",
                               want_found, result.found);
                    end
                end
            end
            if (piece.valid && piece.ready)
            begin
                // values past a full ring are dropped
                if (held_count < MAX_ITEMS)
                begin
                    ring_vals[held_count[9:0]] = piece.piece_value;
                    held_total += 42'(piece.piece_value);
                    held_count++;
                end
                if (piece.last_piece)
                begin
                    expected_found.push_back(ring_has_target_arc());
                    held_total = '0;
                    held_count = '0;
                end
            end
            mismatches <= fail_tally;
            awaiting   <= expected_found.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
// testbench top for the circular arc target sum search: clock, reset, ring stimulus,
// result sink with random stalls and the final verdict
// depends on cats_if, circular_arc_target_sum_search and arc_search_checker
module tb_top;

    localparam int MAX_ITEMS        = 1024;
    localparam int VALUE_BITS       = 32;
    localparam int FRACTION_DIVISOR = 10;
    localparam int RANDOM_ITEMS     = 430;
    localparam int LONG_HOLD        = 400;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    int unsigned mismatch_count;
    int unsigned awaiting_count;
    bit [31:0]   ring_q [$];
    bit [31:0]   piece_parts [$];
    int unsigned items_sent;
    bit          no_gaps;

    cats_piece_if #(.VALUE_BITS(VALUE_BITS)) piece_ch ();
    cats_result_if                           result_ch ();

    circular_arc_target_sum_search #(
        .MAX_ITEMS       (MAX_ITEMS),
        .VALUE_BITS      (VALUE_BITS),
        .FRACTION_DIVISOR(FRACTION_DIVISOR)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .piece (piece_ch),
        .result(result_ch)
    );

    arc_search_checker #(
        .MAX_ITEMS       (MAX_ITEMS),
        .FRACTION_DIVISOR(FRACTION_DIVISOR)
    ) i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .piece     (piece_ch),
        .result    (result_ch),
        .mismatches(mismatch_count),
        .awaiting  (awaiting_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic bit [31:0] rand_piece();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 20);
            1:       return $urandom_range(0, 5000);
            2:       return $urandom;
            default: return ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF
                                                         : 32'd1 << $urandom_range(0, 31);
        endcase
    endfunction

    // spread a sum over a number of pieces, appended to piece_parts
    task automatic split_sum(input longint unsigned total, input int unsigned count);
        longint unsigned left;
        longint unsigned share;
        longint unsigned p;
        int unsigned     i;
        left = total;
        for (i = 0; i < count; i++)
        begin
            if (i == count - 1)
                p = left;
            else
            begin
                share = left * 2 / (count - i);
                if (share > left)
                    share = left;
                p = $urandom_range(0, share[31:0]);
            end
            piece_parts.push_back(p[31:0]);
            left -= p;
        end
    endtask

    // ring that holds an arc of exactly a tenth of its total, rotated at random
    task automatic build_balanced(input int unsigned n);
        longint unsigned goal;
        int unsigned     arc_len;
        int unsigned     shift;
        int unsigned     i;
        arc_len = $urandom_range(1, n - 1);
        goal    = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 200)
                                              : $urandom_range(0, 32'h1C71_C71C);
        piece_parts.delete();
        split_sum(goal, arc_len);
        split_sum(goal * (FRACTION_DIVISOR - 1), n - arc_len);
        shift = $urandom_range(0, n - 1);
        ring_q.delete();
        for (i = 0; i < n; i++)
            ring_q.push_back(piece_parts[(i + shift) % n]);
    endtask

    task automatic build_noise(input int unsigned n);
        int unsigned i;
        ring_q.delete();
        for (i = 0; i < n; i++)
            ring_q.push_back(rand_piece());
    endtask

    // random ring nudged so that its total divides evenly
    task automatic build_divisible(input int unsigned n);
        longint unsigned total;
        int unsigned     r;
        int unsigned     i;
        build_noise(n);
        total = 0;
        for (i = 0; i < n; i++)
            total += ring_q[i];
        r = total % FRACTION_DIVISOR;
        if (r != 0)
        begin
            if (ring_q[n - 1] >= r)
                ring_q[n - 1] -= r;
            else
                ring_q[n - 1] += FRACTION_DIVISOR - r;
        end
    endtask

    task automatic send_piece(input bit [31:0] v, input bit last);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            piece_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        piece_ch.valid       <= 1'b1;
        piece_ch.piece_value <= v;
        piece_ch.last_piece  <= last;
        @(posedge clk);
        while (!piece_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_ring();
        int unsigned i;
        no_gaps = ($urandom_range(0, 4) == 0);
        for (i = 0; i < ring_q.size(); i++)
            send_piece(ring_q[i], i == ring_q.size() - 1);
        items_sent += ring_q.size();
    endtask

    task automatic wait_drained();
        piece_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (awaiting_count != 0);
    endtask

    // result sink: random stalls, runs without stalls, and two long hold-offs
    initial
    begin : result_sink
        int unsigned hold;
        int unsigned taken;
        taken = 0;
        result_ch.ready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (taken == 10 || taken == 60)
                hold = LONG_HOLD;
            else if (taken % 40 < 10)
                hold = 0;
            else
                hold = $urandom_range(0, 3);
            if (hold != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid)
                @(posedge clk);
            taken++;
        end
    end

    initial
    begin : ring_source
        int unsigned ring_no;
        int unsigned n;
        int unsigned i;
        piece_ch.valid       <= 1'b0;
        piece_ch.piece_value <= '0;
        piece_ch.last_piece  <= 1'b0;
        items_sent = 0;
        no_gaps    = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero total: empty arc matches
        ring_q = '{32'd0};
        send_ring();
        // total not divisible by ten
        ring_q = '{32'hFFFF_FFFF};
        send_ring();
        // divisible, but a single piece is larger than the target
        ring_q = '{32'd10};
        send_ring();
        ring_q = '{32'd1, 32'd9};
        send_ring();
        // match only across the wrap point
        ring_q = '{32'd7, 32'd90, 32'd3};
        send_ring();
        // ten full-scale pieces, total beyond 32 bits
        ring_q.delete();
        for (i = 0; i < 10; i++)
            ring_q.push_back(32'hFFFF_FFFF);
        send_ring();
        ring_q = '{32'd0, 32'd0, 32'd0, 32'd0};
        send_ring();

        ring_no = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    if (n >= 2)
                        build_balanced(n);
                    else
                        build_divisible(n);
                end
                6, 7:    build_divisible(n);
                default: build_noise(n);
            endcase
            send_ring();
            ring_no++;
            if (ring_no == 15 || ring_no == 45)
                wait_drained();
        end

        // one more short ring to close
        build_balanced(5);
        send_ring();

        wait_drained();
        repeat (30) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
